[src/key_value_table_oldest_eviction_core_assert.svh]
// Assertion macros used by the key/value table checker.
`ifndef KEY_VALUE_TABLE_OLDEST_EVICTION_CORE_ASSERT_SVH
`define KEY_VALUE_TABLE_OLDEST_EVICTION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define KVTOE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define KVTOE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kvtoe_pkg.sv]
// Types and constants of the key/value table with oldest-entry eviction.
`default_nettype none
package kvtoe_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_ROOM   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_VICTIM,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [63:0] lookup_key;
        logic [63:0] new_value;
        logic        keep_flag;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] found_value;
        logic [5:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] stamp;
        logic        kept;
    } t_entry;

endpackage
`default_nettype wire

[src/key_value_table_oldest_eviction_core.sv]
// A get, delete or set scans the entries from position 0 for the key; a clear empties the table.
// A delete that hits then closes up by moving each later entry one place down.
// A new key into a full table adds a scan for the oldest unkept entry (the victim) and a shift.
// Every step is one read of the single-read-port entry memory; a new item is taken only once the last is done.
// The result strobe comes in the first cycle with busy low; start is taken again in that cycle.
// Synchronous reset empties the table and idles the control; entry memory is not cleared.
`default_nettype none
module key_value_table_oldest_eviction_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire kvtoe_pkg::t_in_item   i_item,
    output logic                       o_strobe,
    output kvtoe_pkg::t_out_item       o_result
);
    import kvtoe_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic              r_have, n_have;
    logic [IDX_W-1:0]  r_victim, n_victim;
    logic [31:0]       r_best, n_best;
    t_in_item          r_in, n_in;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_result, n_result;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    t_entry            new_entry;

    logic accept, scan_issue, scan_end, key_match, better, table_full;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign scan_issue = (r_idx < r_count);
    assign scan_end   = !r_pend && !scan_issue;
    assign key_match  = r_pend && (r_rd_data.key == r_in.lookup_key);
    assign better     = r_pend && !r_rd_data.kept &&
                        (!r_have || (r_rd_data.stamp < r_best));
    assign table_full = (r_count == CNT_W'(ENTRIES));

    assign new_entry.key   = r_in.lookup_key;
    assign new_entry.value = r_in.new_value;
    assign new_entry.stamp = r_in.now_time;
    assign new_entry.kept  = r_in.keep_flag;

    assign o_strobe = r_out_vld;
    assign o_result = r_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (r_in.opcode == OP_CLEAR) begin
                    n_state = S_IDLE;
                end else if (key_match) begin
                    n_state = (r_in.opcode == OP_DELETE) ? S_SHIFT : S_IDLE;
                end else if (scan_end) begin
                    n_state = (r_in.opcode == OP_SET && table_full) ? S_VICTIM : S_IDLE;
                end
            end
            S_VICTIM: begin
                if (scan_end) begin
                    n_state = r_have ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_have    = r_have;
        n_victim  = r_victim;
        n_best    = r_best;
        n_in      = r_in;
        n_out_vld = 1'b0;
        n_result  = r_result;
        rd_en     = 1'b0;
        rd_addr   = r_idx[IDX_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pidx;
        wr_data   = new_entry;

        // The scanning states read one entry per cycle and look at it the next.
        if (r_state != S_IDLE && scan_issue) begin
            rd_en  = 1'b1;
            n_idx  = r_idx + CNT_W'(1);
            n_pend = 1'b1;
            n_pidx = r_idx[IDX_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in   = i_item;
                    n_idx  = '0;
                    n_have = 1'b0;
                end
            end
            S_FIND: begin
                if (r_in.opcode == OP_CLEAR) begin
                    n_count   = '0;
                    n_out_vld = 1'b1;
                    n_result.status      = ST_OK;
                    n_result.found_value = '0;
                end else if (key_match) begin
                    n_out_vld = 1'b1;
                    n_result.status      = ST_OK;
                    n_result.found_value = '0;
                    unique case (r_in.opcode)
                        OP_SET: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pidx;
                        end
                        OP_GET: begin
                            n_result.found_value = r_rd_data.value;
                        end
                        OP_DELETE: begin
                            // Close up from the entry after the hit.
                            n_out_vld = 1'b0;
                            n_idx     = CNT_W'(r_pidx) + CNT_W'(1);
                            n_pend    = 1'b0;
                        end
                        OP_CLEAR: begin
                            n_out_vld = 1'b1;
                        end
                        default: n_out_vld = 1'b1;
                    endcase
                end else if (scan_end) begin
                    n_result.found_value = '0;
                    if (r_in.opcode == OP_SET) begin
                        if (table_full) begin
                            n_idx = '0;
                        end else begin
                            wr_en     = 1'b1;
                            wr_addr   = r_count[IDX_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                            n_out_vld = 1'b1;
                            n_result.status = ST_OK;
                        end
                    end else begin
                        n_out_vld = 1'b1;
                        n_result.status = ST_NOT_FOUND;
                    end
                end
            end
            S_VICTIM: begin
                // Strict less-than keeps the lowest position on equal stamps.
                if (better) begin
                    n_have   = 1'b1;
                    n_victim = r_pidx;
                    n_best   = r_rd_data.stamp;
                end
                if (scan_end) begin
                    if (r_have) begin
                        n_idx  = CNT_W'(r_victim) + CNT_W'(1);
                        n_pend = 1'b0;
                    end else begin
                        n_out_vld = 1'b1;
                        n_result.status      = ST_NO_ROOM;
                        n_result.found_value = '0;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx - IDX_W'(1);
                    wr_data = r_rd_data;
                end
                if (scan_end) begin
                    n_out_vld = 1'b1;
                    n_result.status      = ST_OK;
                    n_result.found_value = '0;
                    if (r_in.opcode == OP_SET) begin
                        // The freed last place takes the new entry; the count is unchanged.
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(r_count - CNT_W'(1));
                        wr_data = new_entry;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase

        n_result.entry_count = 6'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_have   <= n_have;
        r_victim <= n_victim;
        r_best   <= n_best;
        r_in     <= n_in;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[src/kvtoe_checker.sv]
// Port-level checker of the key/value table core and its bind.
`default_nettype none
`include "key_value_table_oldest_eviction_core_assert.svh"
module kvtoe_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_strobe,
    input wire kvtoe_pkg::t_out_item o_result
);
    import kvtoe_pkg::*;

    `KVTOE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `KVTOE_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result strobe while busy")
    `KVTOE_ASSERT_NOW(a_done_strobe, $past(i_rst_n) && $fell(busy), o_strobe, "item ended without a result")
    `KVTOE_ASSERT_NOW(a_miss_zero, o_strobe && o_result.status != ST_OK, o_result.found_value == '0, "value on a failed item")
    `KVTOE_ASSERT_NOW(a_count_range, o_strobe, o_result.entry_count <= 6'(ENTRIES), "entry count beyond capacity")

endmodule

bind key_value_table_oldest_eviction_core kvtoe_checker u_kvtoe_checker (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the key/value table with oldest-entry eviction.
`timescale 1ns / 1ps
module tb_top;
    import kvtoe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int POOL_SIZE      = 48;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    key_value_table_oldest_eviction_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the table, kept in insertion order like the block's.
    logic [63:0] tbl_key   [ENTRIES];
    logic [63:0] tbl_value [ENTRIES];
    logic [31:0] tbl_stamp [ENTRIES];
    logic        tbl_kept  [ENTRIES];
    int          tbl_count = 0;

    t_out_item   pending_results[$];
    logic [63:0] key_pool[POOL_SIZE];
    int          sender_idle_pct = 0;
    int          mismatch_count  = 0;
    int          result_index    = 0;
    int          quiet_cycles    = 0;

    function automatic int find_entry(logic [63:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void remove_entry(int pos);
        for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i]   = tbl_key[i + 1];
            tbl_value[i] = tbl_value[i + 1];
            tbl_stamp[i] = tbl_stamp[i + 1];
            tbl_kept[i]  = tbl_kept[i + 1];
        end
        tbl_count--;
    endfunction

    function automatic t_out_item predict_table_op(t_in_item it);
        t_out_item r;
        int        pos;
        int        victim;
        r.status      = ST_OK;
        r.found_value = '0;
        pos = find_entry(it.lookup_key);
        case (it.opcode)
            OP_SET: begin
                if (pos >= 0) begin
                    tbl_value[pos] = it.new_value;
                    tbl_stamp[pos] = it.now_time;
                    tbl_kept[pos]  = it.keep_flag;
                end else begin
                    if (tbl_count >= ENTRIES) begin
                        // Oldest unkept entry goes; strict compare keeps the lowest on a tie.
                        victim = -1;
                        for (int i = 0; i < tbl_count; i++) begin
                            if (!tbl_kept[i] &&
                                (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
                                victim = i;
                        end
                        if (victim < 0) r.status = ST_NO_ROOM;
                        else remove_entry(victim);
                    end
                    if (r.status == ST_OK) begin
                        tbl_key[tbl_count]   = it.lookup_key;
                        tbl_value[tbl_count] = it.new_value;
                        tbl_stamp[tbl_count] = it.now_time;
                        tbl_kept[tbl_count]  = it.keep_flag;
                        tbl_count++;
                    end
                end
            end
            OP_GET: begin
                if (pos >= 0) r.found_value = tbl_value[pos];
                else r.status = ST_NOT_FOUND;
            end
            OP_DELETE: begin
                if (pos >= 0) remove_entry(pos);
                else r.status = ST_NOT_FOUND;
            end
            default: begin
                tbl_count = 0;
            end
        endcase
        r.entry_count = 6'(tbl_count);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(99, 0) < 85) return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
        return rand64();
    endfunction

    // A few fixed stamps make equal times common, so eviction ties happen.
    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(9, 0))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0005;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic pick_keep(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic send_item(input t_opcode op, input logic [63:0] key,
                             input logic [63:0] value, input logic keep,
                             input logic [31:0] stamp);
        t_in_item it;
        it = '{opcode: op, lookup_key: key, new_value: value, keep_flag: keep,
               now_time: stamp};
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_table_op(it));
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed_ops();
        sender_idle_pct = 0;
        send_item(OP_GET, '0, '0, 1'b0, '0);
        send_item(OP_DELETE, '0, '1, 1'b1, '1);
        send_item(OP_SET, '0, '0, 1'b0, '0);
        send_item(OP_SET, '1, '1, 1'b1, '1);
        send_item(OP_GET, '1, '0, 1'b0, '0);
        send_item(OP_GET, '0, '1, 1'b1, '1);
        send_item(OP_SET, '0, 64'h5555_5555_5555_5555, 1'b1, 32'h1234_5678);
        send_item(OP_GET, '0, '0, 1'b0, '0);
        send_item(OP_DELETE, '1, '0, 1'b0, '0);
        send_item(OP_GET, '1, '0, 1'b0, '0);
        send_item(OP_SET, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
                  32'h5555_5555);
        send_item(OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0);
        send_item(OP_CLEAR, '1, '1, 1'b1, '1);
        send_item(OP_GET, '0, '0, 1'b0, '0);
        send_item(OP_SET, 64'h0123_4567_89AB_CDEF, rand64(), 1'b1, '0);
        send_item(OP_SET, 64'h0123_4567_89AB_CDEE, rand64(), 1'b0, '1);
        send_item(OP_DELETE, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0);
        send_item(OP_GET, 64'h0123_4567_89AB_CDEE, '0, 1'b0, '0);
        send_item(OP_CLEAR, '0, '0, 1'b0, '0);
        drain_results();
    endtask

    task automatic test_eviction_order();
        sender_idle_pct = 0;
        // Equal stamps everywhere: the entry at the front must be the one evicted.
        for (int i = 0; i < ENTRIES; i++)
            send_item(OP_SET, 64'h1000 + i, rand64(), 1'b0, 32'd100);
        send_item(OP_SET, 64'h2000, rand64(), 1'b0, 32'd100);
        send_item(OP_GET, 64'h1000, '0, 1'b0, '0);
        send_item(OP_GET, 64'h1001, '0, 1'b0, '0);
        send_item(OP_CLEAR, '0, '0, 1'b0, '0);
        // One unkept entry stamped all ones among kept ones is still evicted.
        for (int i = 0; i < ENTRIES; i++)
            send_item(OP_SET, 64'h3000 + i, rand64(), i != 7, i == 7 ? '1 : $urandom);
        send_item(OP_SET, 64'h4000, rand64(), 1'b0, 32'd9);
        send_item(OP_SET, 64'h4001, rand64(), 1'b1, 32'd3);
        send_item(OP_SET, 64'h4002, rand64(), 1'b0, 32'd1);
        send_item(OP_SET, 64'h3003, rand64(), 1'b0, '1);
        send_item(OP_SET, 64'h4003, rand64(), 1'b1, '0);
        send_item(OP_GET, 64'h3003, '0, 1'b0, '0);
        drain_results();
    endtask

    task automatic test_random_mix(input int n, input int idle_pct);
        int r;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 45)      send_item(OP_SET, pick_key(), rand64(), pick_keep(25), pick_stamp());
            else if (r < 70) send_item(OP_GET, pick_key(), rand64(), 1'($urandom), $urandom);
            else if (r < 97) send_item(OP_DELETE, pick_key(), rand64(), 1'($urandom), $urandom);
            else             send_item(OP_CLEAR, rand64(), rand64(), 1'($urandom), $urandom);
        end
        drain_results();
    endtask

    task automatic test_full_table(input int n, input int keep_pct, input int idle_pct);
        int r;
        sender_idle_pct = idle_pct;
        send_item(OP_CLEAR, rand64(), rand64(), 1'($urandom), $urandom);
        for (int i = 0; i < ENTRIES; i++)
            send_item(OP_SET, pick_key(), rand64(), pick_keep(keep_pct), pick_stamp());
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 62)      send_item(OP_SET, pick_key(), rand64(), pick_keep(keep_pct),
                                       pick_stamp());
            else if (r < 85) send_item(OP_GET, pick_key(), rand64(), 1'($urandom), $urandom);
            else             send_item(OP_DELETE, pick_key(), rand64(), 1'($urandom), $urandom);
        end
        drain_results();
    endtask

    task automatic test_all_kept(input int rounds, input int idle_pct);
        logic [63:0] base;
        sender_idle_pct = idle_pct;
        for (int k = 0; k < rounds; k++) begin
            base = rand64() & ~64'hFF;
            send_item(OP_CLEAR, rand64(), rand64(), 1'($urandom), $urandom);
            for (int i = 0; i < ENTRIES; i++)
                send_item(OP_SET, base + i, rand64(), pick_keep(90), pick_stamp());
            for (int i = 0; i < 8; i++)
                send_item(OP_SET, base + 64 + i, rand64(), 1'b1, pick_stamp());
            // Releasing a kept entry makes it a candidate for the next new key.
            send_item(OP_SET, base + 5, rand64(), 1'b0, pick_stamp());
            send_item(OP_SET, base + 80, rand64(), 1'b1, pick_stamp());
            send_item(OP_GET, base + 5, '0, 1'b0, '0);
            send_item(OP_SET, base + 81, rand64(), 1'b0, pick_stamp());
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            result_index++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with none expected: status %0d value %h count %0d",
                             result_index, o_result.status, o_result.found_value,
                             o_result.entry_count);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.found_value !== want.found_value ||
                    o_result.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected status %0d value %h count %0d, got status %0d value %h count %0d",
                                 result_index, want.status, want.found_value,
                                 want.entry_count, o_result.status,
                                 o_result.found_value, o_result.entry_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_eviction_order();
        test_random_mix(210, 0);
        test_random_mix(250, 88);
        test_random_mix(250, 31);
        test_full_table(200, 10, 0);
        test_full_table(150, 50, 31);
        test_full_table(60, 20, 88);
        test_all_kept(3, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/kvtoe_pkg.sv
src/key_value_table_oldest_eviction_core.sv
src/kvtoe_checker.sv
tb/sv/tb_top.sv
